[sv/assert_macros.svh]
// Assertion macros for concurrent checks, included by the shadow call stack core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A clocked property that is switched off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// An overlapping implication built on the clocked form above.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

[sv/pcs_pkg.sv]
// Shared types and constants of the per-thread shadow call stack.
package pcs_pkg;

   localparam int THREAD_SLOTS_DEF = 64;
   localparam int STACK_DEPTH_DEF  = 64;

   localparam int TID_W       = 22;
   localparam int ADDR_W      = 32;
   localparam int DEPTH_OUT_W = 7;

   typedef enum logic [0:0] {
      CMD_ENTER = 1'b0,
      CMD_EXIT  = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_UNKNOWN  = 3'd2,
      ST_MISMATCH = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   typedef logic [TID_W-1:0]       tid_type;
   typedef logic [ADDR_W-1:0]      addr_type;
   typedef logic [DEPTH_OUT_W-1:0] depth_out_type;

endpackage

[sv/pcs_if.sv]
// Valid/ready channel interfaces for event words and status words.
interface pcs_req_if import pcs_pkg::*; ();
   logic     valid;
   logic     ready;
   cmd_type  cmd;
   tid_type  thread_id;
   addr_type func_addr;
   addr_type ret_addr;

   modport source (output valid, cmd, thread_id, func_addr, ret_addr, input ready);
   modport sink   (input valid, cmd, thread_id, func_addr, ret_addr, output ready);
endinterface

interface pcs_rsp_if import pcs_pkg::*; ();
   logic          valid;
   logic          ready;
   status_type    status;
   addr_type      popped_call_site;
   depth_out_type depth_after;

   modport source (output valid, status, popped_call_site, depth_after, input ready);
   modport sink   (input valid, status, popped_call_site, depth_after, output ready);
endinterface

[sv/pcs_ram.sv]
// Simple dual-port synchronous RAM with one write port and a registered read port.
module pcs_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 2,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[sv/per_thread_shadow_call_stack_core.sv]
// Top level of the per-thread shadow call stack: slot scan, push/pop sequencer, result register.
// Steps: a zero thread id is answered as unknown without a scan; an enter or an exit first scans
// the slot table RAM one entry per cycle, and an exit then reads and checks the top frame.
// Throughput: one word at a time; the next word is taken on the cycle after the result is staged.
// Reset: synchronous; afterwards a clearing pass writes every slot entry, one per cycle,
// and no word is accepted until it ends. The frame RAM is not cleared.
`include "assert_macros.svh"

module per_thread_shadow_call_stack_core import pcs_pkg::*; #(
   parameter int THREAD_SLOTS = THREAD_SLOTS_DEF,
   parameter int STACK_DEPTH  = STACK_DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   pcs_req_if.sink    req_bus,
   pcs_rsp_if.source  rsp_bus
);

   localparam int SW     = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
   localparam int CW     = $clog2(THREAD_SLOTS + 1);
   localparam int DW     = $clog2(STACK_DEPTH + 1);
   localparam int FRAMES = THREAD_SLOTS * STACK_DEPTH;
   localparam int FW     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int SLOT_W = TID_W + DW;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_POP,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0] iss_ff, iss_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic [SW-1:0] cmp_idx_ff, cmp_idx_in;
   logic          own_hit_ff, own_hit_in;
   logic [SW-1:0] own_idx_ff, own_idx_in;
   logic [DW-1:0] own_dep_ff, own_dep_in;
   logic          free_hit_ff, free_hit_in;
   logic [SW-1:0] free_idx_ff, free_idx_in;

   cmd_type  cmd_ff, cmd_in;
   tid_type  tid_ff, tid_in;
   addr_type func_ff, func_in;
   addr_type site_ff, site_in;

   status_type    res_status_ff, res_status_in;
   addr_type      res_site_ff, res_site_in;
   depth_out_type res_depth_ff, res_depth_in;

   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   addr_type      rsp_site_ff, rsp_site_in;
   depth_out_type rsp_depth_ff, rsp_depth_in;

   logic              slot_we;
   logic [SW-1:0]     slot_waddr;
   logic [SLOT_W-1:0] slot_wdata;
   logic [SW-1:0]     slot_raddr;
   logic [SLOT_W-1:0] slot_rdata;
   tid_type           slot_rd_tid;
   logic [DW-1:0]     slot_rd_dep;

   logic          frame_we;
   logic [FW-1:0] frame_waddr;
   logic [63:0]   frame_wdata;
   logic [FW-1:0] frame_raddr;
   logic [63:0]   frame_rdata;

   logic          sel_ok;
   logic [SW-1:0] sel_idx;
   logic [DW-1:0] sel_dep;
   logic [DW-1:0] pop_dep;
   logic          req_fire;

   pcs_ram #(.WIDTH(SLOT_W), .DEPTH(THREAD_SLOTS)) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata (slot_wdata),
      .raddr (slot_raddr),
      .rdata (slot_rdata)
   );

   pcs_ram #(.WIDTH(64), .DEPTH(FRAMES)) u_frame_ram (
      .clock (clock),
      .we    (frame_we),
      .waddr (frame_waddr),
      .wdata (frame_wdata),
      .raddr (frame_raddr),
      .rdata (frame_rdata)
   );

   assign slot_rd_tid = slot_rdata[SLOT_W-1:DW];
   assign slot_rd_dep = slot_rdata[DW-1:0];

   // A free slot always holds depth zero, so only an owner brings a stored depth.
   assign sel_ok  = own_hit_ff || free_hit_ff;
   assign sel_idx = own_hit_ff ? own_idx_ff : free_idx_ff;
   assign sel_dep = own_hit_ff ? own_dep_ff : '0;
   assign pop_dep = DW'(own_dep_ff - 1'b1);

   // Each slot owns STACK_DEPTH consecutive frame entries.
   assign frame_waddr = FW'(FW'(sel_idx) * FW'(STACK_DEPTH)) + FW'(sel_dep);
   assign frame_raddr = FW'(FW'(own_idx_ff) * FW'(STACK_DEPTH)) + FW'(pop_dep);
   assign frame_wdata = {func_ff, site_ff};
   assign slot_raddr  = iss_ff[SW-1:0];

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;

   always_comb begin
      state_in      = state_ff;
      iss_in        = iss_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      own_hit_in    = own_hit_ff;
      own_idx_in    = own_idx_ff;
      own_dep_in    = own_dep_ff;
      free_hit_in   = free_hit_ff;
      free_idx_in   = free_idx_ff;
      cmd_in        = cmd_ff;
      tid_in        = tid_ff;
      func_in       = func_ff;
      site_in       = site_ff;
      res_status_in = res_status_ff;
      res_site_in   = res_site_ff;
      res_depth_in  = res_depth_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_site_in   = rsp_site_ff;
      rsp_depth_in  = rsp_depth_ff;
      slot_we       = 1'b0;
      slot_waddr    = sel_idx;
      slot_wdata    = '0;
      frame_we      = 1'b0;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            slot_we    = 1'b1;
            slot_waddr = iss_ff[SW-1:0];
            if (iss_ff == CW'(THREAD_SLOTS - 1)) begin
               iss_in   = '0;
               state_in = S_IDLE;
            end else begin
               iss_in = CW'(iss_ff + 1'b1);
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               cmd_in      = req_bus.cmd;
               tid_in      = req_bus.thread_id;
               func_in     = req_bus.func_addr;
               site_in     = req_bus.ret_addr;
               iss_in      = '0;
               own_hit_in  = 1'b0;
               free_hit_in = 1'b0;
               if (req_bus.thread_id == '0) begin
                  res_status_in = ST_UNKNOWN;
                  res_site_in   = '0;
                  res_depth_in  = '0;
                  state_in      = S_FINISH;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // Reads are issued one slot per cycle; the compare trails by the RAM latency.
            if (iss_ff != CW'(THREAD_SLOTS)) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = iss_ff[SW-1:0];
               iss_in     = CW'(iss_ff + 1'b1);
            end
            if (cmp_vld_ff) begin
               if (slot_rd_tid == tid_ff) begin
                  own_hit_in = 1'b1;
                  own_idx_in = cmp_idx_ff;
                  own_dep_in = slot_rd_dep;
               end
               if ((slot_rd_tid == '0) && !free_hit_ff) begin
                  free_hit_in = 1'b1;
                  free_idx_in = cmp_idx_ff;
               end
            end
            if ((iss_ff == CW'(THREAD_SLOTS)) && !cmp_vld_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            res_site_in = '0;
            if (cmd_ff == CMD_ENTER) begin
               state_in = S_FINISH;
               if (!sel_ok) begin
                  res_status_in = ST_FULL;
                  res_depth_in  = '0;
               end else if (sel_dep >= DW'(STACK_DEPTH)) begin
                  res_status_in = ST_OVERFLOW;
                  res_depth_in  = DEPTH_OUT_W'(sel_dep);
               end else begin
                  frame_we      = 1'b1;
                  slot_we       = 1'b1;
                  slot_wdata    = {tid_ff, DW'(sel_dep + 1'b1)};
                  res_status_in = ST_OK;
                  res_depth_in  = DEPTH_OUT_W'(DW'(sel_dep + 1'b1));
               end
            end else if (!own_hit_ff) begin
               res_status_in = ST_UNKNOWN;
               res_depth_in  = '0;
               state_in      = S_FINISH;
            end else begin
               // The top frame read is issued this cycle and checked in the next.
               state_in = S_POP;
            end
         end
         S_POP: begin
            state_in = S_FINISH;
            if (frame_rdata[63:32] != func_ff) begin
               res_status_in = ST_MISMATCH;
               res_site_in   = '0;
               res_depth_in  = DEPTH_OUT_W'(own_dep_ff);
            end else begin
               slot_we       = 1'b1;
               slot_waddr    = own_idx_ff;
               slot_wdata    = (pop_dep == '0) ? '0 : {tid_ff, pop_dep};
               res_status_in = ST_OK;
               res_site_in   = frame_rdata[31:0];
               res_depth_in  = DEPTH_OUT_W'(pop_dep);
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_site_in   = res_site_ff;
               rsp_depth_in  = res_depth_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         iss_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         own_hit_ff   <= 1'b0;
         free_hit_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         cmp_vld_ff   <= cmp_vld_in;
         own_hit_ff   <= own_hit_in;
         free_hit_ff  <= free_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmp_idx_ff    <= cmp_idx_in;
      own_idx_ff    <= own_idx_in;
      own_dep_ff    <= own_dep_in;
      free_idx_ff   <= free_idx_in;
      cmd_ff        <= cmd_in;
      tid_ff        <= tid_in;
      func_ff       <= func_in;
      site_ff       <= site_in;
      res_status_ff <= res_status_in;
      res_site_ff   <= res_site_in;
      res_depth_ff  <= res_depth_in;
      rsp_status_ff <= rsp_status_in;
      rsp_site_ff   <= rsp_site_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.status           = rsp_status_ff;
   assign rsp_bus.popped_call_site = rsp_site_ff;
   assign rsp_bus.depth_after      = rsp_depth_ff;

   `ASSERT_IMPLIES(a_push_in_bounds, frame_we, sel_dep < DW'(STACK_DEPTH), "push past stack bound")
   `ASSERT_IMPLIES(a_tagged_slot_nonempty, slot_we && (slot_wdata[SLOT_W-1:DW] != '0), slot_wdata[DW-1:0] != '0, "owned slot written with zero depth")
   `ASSERT_IMPLIES(a_pop_has_owner, state_ff == S_POP, own_hit_ff && (own_dep_ff != '0), "pop without an owning slot")
   `ASSERT_CLK(a_accept_leaves_idle, req_fire |=> (state_ff != S_IDLE), "word accepted but sequencer stayed idle")

endmodule
